// File: src/wm_pkg.sv
// package for the wildcard matcher: types, sizes and the control store
package wm_pkg;

  localparam int unsigned MASK_DEPTH = 64;
  localparam int unsigned NAME_DEPTH = 256;
  localparam int unsigned MASK_AW = $clog2(MASK_DEPTH);
  localparam int unsigned NAME_AW = $clog2(NAME_DEPTH);
  localparam int unsigned MASK_LW = $clog2(MASK_DEPTH + 1);
  localparam int unsigned NAME_LW = $clog2(NAME_DEPTH + 1);
  localparam int unsigned SYM_W = 8;

  localparam logic [SYM_W-1:0] CH_ANY_ONE = 8'h3F;
  localparam logic [SYM_W-1:0] CH_ANY_RUN = 8'h2A;

  localparam logic MODE_MASK = 1'b0;
  localparam logic MODE_NAME = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SYM_W-1:0] symbol;
    logic             has_symbol;
    logic             last;
  } wm_in_t;

  typedef struct packed {
    logic matched;
    logic overflow;
  } wm_out_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_INIT  = 3'd1,
    ST_LTEST = 3'd2,
    ST_CMP   = 3'd3,
    ST_TTEST = 3'd4,
    ST_TCHK  = 3'd5,
    ST_HIT   = 3'd6,
    ST_MISS  = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_INIT,
    OP_LTEST,
    OP_CMP,
    OP_TTEST,
    OP_TCHK,
    OP_EMIT
  } op_e;

  // one control word: operation, taken target, alternate target, result bit
  typedef struct packed {
    op_e   op;
    step_e nxt;
    step_e alt;
    logic  hit;
  } ctrl_t;

  function automatic ctrl_t wm_ucode(step_e s);
    ctrl_t w;
    unique case (s)
      ST_IDLE:  w = '{op: OP_IDLE,  nxt: ST_INIT,  alt: ST_IDLE,  hit: 1'b0};
      ST_INIT:  w = '{op: OP_INIT,  nxt: ST_LTEST, alt: ST_MISS,  hit: 1'b0};
      ST_LTEST: w = '{op: OP_LTEST, nxt: ST_CMP,   alt: ST_TTEST, hit: 1'b0};
      ST_CMP:   w = '{op: OP_CMP,   nxt: ST_LTEST, alt: ST_MISS,  hit: 1'b0};
      ST_TTEST: w = '{op: OP_TTEST, nxt: ST_TCHK,  alt: ST_HIT,   hit: 1'b0};
      ST_TCHK:  w = '{op: OP_TCHK,  nxt: ST_TTEST, alt: ST_MISS,  hit: 1'b0};
      ST_HIT:   w = '{op: OP_EMIT,  nxt: ST_IDLE,  alt: ST_HIT,   hit: 1'b1};
      ST_MISS:  w = '{op: OP_EMIT,  nxt: ST_IDLE,  alt: ST_MISS,  hit: 1'b0};
      default:  w = '{op: OP_IDLE,  nxt: ST_INIT,  alt: ST_IDLE,  hit: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// File: src/wm_ram.sv
// generic single-port-write, single-port-read ram with registered read
module wm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/wildcard_match.sv
// wildcard matcher top level: '?' matches one character, '*' any run
//
// Input words (valid/ready) carry mode, symbol, has_symbol and last. Mode 0
// words load mask characters, mode 1 words load name characters, one word
// per cycle while the matcher is idle. A word with last closes its string;
// the next word of that kind starts a new one. A mask stays loaded for any
// number of names.
// The name word with last starts the matcher, a microcoded sequencer that
// walks both buffers with a greedy scan and backtracks to the latest star.
// Each compare reads both buffers through the registered ram read and then
// decides, and each trailing star of the tail check takes a further test and
// check. A valid result follows the last name word once the compares, at most
// about mask_length*name_length with backtracking, and the tail stars are done;
// a miss with no star to fall back on skips the tail check, and an overflowed
// string skips the scan. Ready stays low while the scan runs.
// One result word (matched, overflow) per name; it waits in an output
// register while the receiver stalls, and loading may go on meanwhile. A
// further result waits in the sequencer with ready low until that one is taken.
// Reset empties both strings and clears the error, overflow and output valid
// flags; buffer contents need no clearing.
module wildcard_match
  import wm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  wm_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output wm_out_t out_data_o
);

  step_e step_q, step_d;
  ctrl_t ctrl;

  logic [MASK_LW-1:0] ml_q, ml_d, mc_q, mc_d, sp_q, sp_d;
  logic [NAME_LW-1:0] nl_q, nl_d, nc_q, nc_d, rp_q, rp_d;
  logic mask_err_q, mask_err_d, name_err_q, name_err_d;
  logic mask_fresh_q, mask_fresh_d, name_fresh_q, name_fresh_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  wm_out_t out_q, out_d;

  logic               mask_we, name_we;
  logic [MASK_LW-1:0] ml_eff;
  logic [NAME_LW-1:0] nl_eff;
  logic [SYM_W-1:0]   mask_sym, name_sym;
  logic               accept, mvalid;

  assign ctrl = wm_ucode(step_q);
  assign in_ready_o = (ctrl.op == OP_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign ml_eff = mask_fresh_q ? '0 : ml_q;
  assign nl_eff = name_fresh_q ? '0 : nl_q;
  assign mvalid = (mc_q < ml_q);

  wm_ram #(.WIDTH(SYM_W), .DEPTH(MASK_DEPTH)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .waddr_i (ml_eff[MASK_AW-1:0]),
    .wdata_i (in_data_i.symbol),
    .raddr_i (mc_q[MASK_AW-1:0]),
    .rdata_o (mask_sym)
  );

  wm_ram #(.WIDTH(SYM_W), .DEPTH(NAME_DEPTH)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (nl_eff[NAME_AW-1:0]),
    .wdata_i (in_data_i.symbol),
    .raddr_i (nc_q[NAME_AW-1:0]),
    .rdata_o (name_sym)
  );

  always_comb begin
    step_d       = step_q;
    ml_d         = ml_q;
    nl_d         = nl_q;
    mc_d         = mc_q;
    nc_d         = nc_q;
    sp_d         = sp_q;
    rp_d         = rp_q;
    mask_err_d   = mask_err_q;
    name_err_d   = name_err_q;
    mask_fresh_d = mask_fresh_q;
    name_fresh_d = name_fresh_q;
    ovf_d        = ovf_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mask_we      = 1'b0;
    name_we      = 1'b0;

    unique case (ctrl.op)
      OP_IDLE: begin
        if (accept) begin
          if (in_data_i.mode == MODE_MASK) begin
            ml_d         = ml_eff;
            mask_err_d   = mask_fresh_q ? 1'b0 : mask_err_q;
            mask_fresh_d = in_data_i.last;
            if (in_data_i.has_symbol) begin
              if (ml_eff < MASK_LW'(MASK_DEPTH)) begin
                mask_we = 1'b1;
                ml_d    = ml_eff + 1'b1;
              end else begin
                mask_err_d = 1'b1;
              end
            end
          end else begin
            nl_d         = nl_eff;
            name_err_d   = name_fresh_q ? 1'b0 : name_err_q;
            name_fresh_d = in_data_i.last;
            if (in_data_i.has_symbol) begin
              if (nl_eff < NAME_LW'(NAME_DEPTH)) begin
                name_we = 1'b1;
                nl_d    = nl_eff + 1'b1;
              end else begin
                name_err_d = 1'b1;
              end
            end
            if (in_data_i.last) begin
              ovf_d  = name_err_d || mask_err_q;
              step_d = ctrl.nxt;
            end
          end
        end
      end
      OP_INIT: begin
        mc_d   = '0;
        nc_d   = '0;
        sp_d   = '0;
        rp_d   = '0;
        step_d = ovf_q ? ctrl.alt : ctrl.nxt;
      end
      OP_LTEST: begin
        step_d = (nc_q >= nl_q) ? ctrl.alt : ctrl.nxt;
      end
      OP_CMP: begin
        step_d = ctrl.nxt;
        priority if (mvalid && mask_sym == CH_ANY_RUN) begin
          mc_d = mc_q + 1'b1;
          sp_d = mc_q + 1'b1;
          rp_d = nc_q;
        end else if (mvalid && (mask_sym == CH_ANY_ONE || mask_sym == name_sym)) begin
          mc_d = mc_q + 1'b1;
          nc_d = nc_q + 1'b1;
        end else if (sp_q != '0) begin
          mc_d = sp_q;
          rp_d = rp_q + 1'b1;
          nc_d = rp_q + 1'b1;
        end else begin
          step_d = ctrl.alt;
        end
      end
      OP_TTEST: begin
        step_d = mvalid ? ctrl.nxt : ctrl.alt;
      end
      OP_TCHK: begin
        if (mask_sym == CH_ANY_RUN) begin
          mc_d   = mc_q + 1'b1;
          step_d = ctrl.nxt;
        end else begin
          step_d = ctrl.alt;
        end
      end
      OP_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d    = 1'b1;
          out_d.matched  = ctrl.hit && !ovf_q;
          out_d.overflow = ovf_q;
          step_d         = ctrl.nxt;
        end else begin
          step_d = ctrl.alt;
        end
      end
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= ST_IDLE;
      ml_q         <= '0;
      nl_q         <= '0;
      mc_q         <= '0;
      nc_q         <= '0;
      sp_q         <= '0;
      rp_q         <= '0;
      mask_err_q   <= 1'b0;
      name_err_q   <= 1'b0;
      mask_fresh_q <= 1'b1;
      name_fresh_q <= 1'b1;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q       <= step_d;
      ml_q         <= ml_d;
      nl_q         <= nl_d;
      mc_q         <= mc_d;
      nc_q         <= nc_d;
      sp_q         <= sp_d;
      rp_q         <= rp_d;
      mask_err_q   <= mask_err_d;
      name_err_q   <= name_err_d;
      mask_fresh_q <= mask_fresh_d;
      name_fresh_q <= name_fresh_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
